// ===== design/sm4_pkg.sv =====
// SM4 block cipher package: constants, S-box and round functions.
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int ROUND_W    = 5;
    localparam int CFG_IDX_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    typedef enum logic {
        CMD_ENC = 1'b0,
        CMD_DEC = 1'b1
    } sm4_cmd_t;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Apply the S-box to each byte of a word
    function automatic logic [31:0] subst_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // Data path transform: S-box then L
    function automatic logic [31:0] data_mix(input logic [31:0] v);
        logic [31:0] b;
        b = subst_word(v);
        return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    endfunction

    // Key schedule transform: S-box then L'
    function automatic logic [31:0] key_mix(input logic [31:0] v);
        logic [31:0] b;
        b = subst_word(v);
        return b ^ rotl32(b, 13) ^ rotl32(b, 23);
    endfunction

    // CK constant: byte j of word i is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] i);
        logic [31:0] w;
        logic [6:0]  base;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            base = {i, 2'(j)};
            w = {w[23:0], 8'(base * 7)};
        end
        return w;
    endfunction

    // One cipher round on a window of four words, oldest word in the top bits
    function automatic logic [127:0] cipher_round(input logic [127:0] x,
                                                  input logic [31:0]  rk);
        logic [31:0] t;
        t = x[95:64] ^ x[63:32] ^ x[31:0] ^ rk;
        return {x[95:0], x[127:96] ^ data_mix(t)};
    endfunction

endpackage

// ===== design/sm4_in_if.sv =====
// Input block channel: command and 128-bit block.
`timescale 1ns / 1ps

interface sm4_in_if;
    logic               valid;
    logic               ready;
    sm4_pkg::sm4_cmd_t  cmd;
    logic [63:0]        block_high;
    logic [63:0]        block_low;

    modport source (output valid, cmd, block_high, block_low, input ready);
    modport sink   (input valid, cmd, block_high, block_low, output ready);
endinterface

// ===== design/sm4_out_if.sv =====
// Result block channel: 128-bit output block.
`timescale 1ns / 1ps

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ===== design/sm4_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface sm4_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sm4_pkg::CFG_IDX_W-1:0]    index;
    logic [63:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sm4_block_cipher_top.sv =====
// SM4 block cipher top level: iterative key schedule and 32-stage round pipeline.
`timescale 1ns / 1ps

// Usage
//   cfg  : write key_high (index 0) and key_low (index 1), 64 bits each, only
//          while the block is idle. Each write restarts key expansion from the
//          current key; other indexes are ignored. cfg.ready is always high.
//   din  : one beat per 128-bit block, cmd 0 encrypts, 1 decrypts.
//   dout : one beat per input beat, in the same order.
// Pipeline and throughput
//   One round per pipeline stage, 32 stages: an accepted block passes through
//   the stages in order and leaves the last stage on dout when dout.ready is high.
//   One block is accepted every cycle unless the pipeline stalls or key expansion runs.
//   Key expansion runs one round per cycle in a shared key schedule unit
//   after reset or after a key write; din.ready stays low while it runs.
// Reset
//   Clears the key to zero and starts expansion of the all-zero key; the
//   pipeline empties.
// Stall
//   When dout holds a beat and dout.ready is low, the whole pipeline holds,
//   bubbles included, and din.ready drops until the result leaves; no beat is
//   lost or repeated.
module sm4_block_cipher_top (
    input  logic         clk,
    input  logic         rst_n,
    sm4_cfg_if.sink      cfg,
    sm4_in_if.sink       din,
    sm4_out_if.source    dout
);
    import sm4_pkg::*;

    // Key registers and key schedule state
    logic [63:0]          key_high_reg, key_high_next;
    logic [63:0]          key_low_reg,  key_low_next;
    logic [31:0]          kwin_reg [4];
    logic [31:0]          kwin_next [4];
    logic [ROUND_W-1:0]   key_cnt_reg, key_cnt_next;
    logic                 busy_reg, busy_next;
    logic                 key_load;
    logic [31:0]          key_new;
    logic [31:0]          rk_reg [NUM_ROUNDS];

    // Round pipeline
    logic                 stage_valid_reg [NUM_ROUNDS];
    sm4_cmd_t             stage_cmd_reg   [NUM_ROUNDS];
    logic [127:0]         stage_data_reg  [NUM_ROUNDS];
    logic [127:0]         stage_in_data   [NUM_ROUNDS];
    sm4_cmd_t             stage_in_cmd    [NUM_ROUNDS];
    logic [31:0]          stage_rk        [NUM_ROUNDS];
    logic                 advance;
    logic                 in_fire;
    logic                 cfg_fire;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // Decode key writes
    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        key_load      = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                REG_KEY_HIGH:
                begin
                    key_high_next = cfg.data;
                    key_load      = 1'b1;
                end
                REG_KEY_LOW:
                begin
                    key_low_next = cfg.data;
                    key_load     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Advance the key schedule by one round
    assign key_new = kwin_reg[0] ^ key_mix(kwin_reg[1] ^ kwin_reg[2] ^ kwin_reg[3]
                                           ^ ck_word(key_cnt_reg));

    always_comb
    begin
        kwin_next    = kwin_reg;
        key_cnt_next = key_cnt_reg;
        busy_next    = busy_reg;
        if (key_load)
        begin
            kwin_next[0] = key_high_next[63:32] ^ FK0;
            kwin_next[1] = key_high_next[31:0]  ^ FK1;
            kwin_next[2] = key_low_next[63:32]  ^ FK2;
            kwin_next[3] = key_low_next[31:0]   ^ FK3;
            key_cnt_next = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            kwin_next[0] = kwin_reg[1];
            kwin_next[1] = kwin_reg[2];
            kwin_next[2] = kwin_reg[3];
            kwin_next[3] = key_new;
            key_cnt_next = key_cnt_reg + 1'b1;
            if (key_cnt_reg == ROUND_W'(NUM_ROUNDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold key and schedule state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            kwin_reg[0]  <= FK0;
            kwin_reg[1]  <= FK1;
            kwin_reg[2]  <= FK2;
            kwin_reg[3]  <= FK3;
            key_cnt_reg  <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            kwin_reg     <= kwin_next;
            key_cnt_reg  <= key_cnt_next;
            busy_reg     <= busy_next;
        end
    end

    // Store each round key as the schedule produces it
    always_ff @(posedge clk)
    begin
        if (busy_reg && !key_load)
        begin
            rk_reg[key_cnt_reg] <= key_new;
        end
    end

    // Move the pipeline when the output slot is free or being drained
    assign advance   = !stage_valid_reg[NUM_ROUNDS-1] || dout.ready;
    assign din.ready = advance && !busy_reg;
    assign in_fire   = din.valid && din.ready;

    // Select each stage's source and round key
    always_comb
    begin
        for (int s = 0; s < NUM_ROUNDS; s++)
        begin
            if (s == 0)
            begin
                stage_in_data[s] = {din.block_high, din.block_low};
                stage_in_cmd[s]  = din.cmd;
            end
            else
            begin
                stage_in_data[s] = stage_data_reg[s-1];
                stage_in_cmd[s]  = stage_cmd_reg[s-1];
            end
            stage_rk[s] = (stage_in_cmd[s] == CMD_DEC) ? rk_reg[NUM_ROUNDS-1-s] : rk_reg[s];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_ROUNDS; s++)
            begin
                stage_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stage_valid_reg[0] <= in_fire;
            for (int s = 1; s < NUM_ROUNDS; s++)
            begin
                stage_valid_reg[s] <= stage_valid_reg[s-1];
            end
        end
    end

    // Advance round data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NUM_ROUNDS; s++)
            begin
                stage_data_reg[s] <= cipher_round(stage_in_data[s], stage_rk[s]);
                stage_cmd_reg[s]  <= stage_in_cmd[s];
            end
        end
    end

    // Drive the result beat, final words in reverse order
    assign dout.valid       = stage_valid_reg[NUM_ROUNDS-1];
    assign dout.result_high = {stage_data_reg[NUM_ROUNDS-1][31:0],
                               stage_data_reg[NUM_ROUNDS-1][63:32]};
    assign dout.result_low  = {stage_data_reg[NUM_ROUNDS-1][95:64],
                               stage_data_reg[NUM_ROUNDS-1][127:96]};

    // No block enters while round keys are being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !busy_reg)
        else $error("block accepted during key expansion");

    // A key write restarts expansion from the first round
    assert property (@(posedge clk) disable iff (!rst_n)
        key_load |=> (busy_reg && key_cnt_reg == '0))
        else $error("key write did not restart expansion");

    // Expansion ends only after the last round key
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(key_cnt_reg) == ROUND_W'(NUM_ROUNDS - 1))
        else $error("key expansion ended early");

    // A stalled result stays in the output stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.ready) |=> stage_valid_reg[NUM_ROUNDS-1])
        else $error("stalled result dropped");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SM4 block cipher: key writes, block traffic, result checks.
`timescale 1ns / 1ps

module tb_top;
    import sm4_pkg::*;

    localparam int DRAIN_CYCLES  = 64;
    localparam int SQUEEZE_AT    = 250;
    localparam int SQUEEZE_LEN   = 120;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 110;

    // Register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_KEY_LOW + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    // Published SM4 example: key equals plaintext, with its ciphertext
    localparam logic [63:0] STD_WORD_HIGH = 64'h0123456789abcdef;
    localparam logic [63:0] STD_WORD_LOW  = 64'hfedcba9876543210;
    localparam logic [63:0] STD_CT_HIGH   = 64'h681edf34d206965e;
    localparam logic [63:0] STD_CT_LOW    = 64'h86b3e94f536e4246;

    // S-box, byte 0 in the top bits
    localparam logic [2047:0] SBOX_BITS = {
        128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    typedef struct {
        sm4_cmd_t    cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } cipher_req_t;

    logic clk;
    logic rst_n;

    sm4_cfg_if cfg_bus ();
    sm4_in_if  din_bus ();
    sm4_out_if dout_bus ();

    sm4_block_cipher_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    // Predictor state: key registers and expanded round keys
    logic [63:0] model_key_high;
    logic [63:0] model_key_low;
    logic [31:0] model_round_keys [32];

    cipher_req_t  pending_blocks [$];
    logic [127:0] expected_blocks [$];

    int  mismatches  = 0;
    int  beats_in    = 0;
    int  send_gap    = 0;
    int  stall_left  = 0;
    int  squeeze_left = 0;
    bit  squeeze_done = 1'b0;
    bit  in_taken    = 1'b0;
    bit  jitter_on   = 1'b1;

    function automatic logic [7:0] sbox_lookup(input logic [7:0] b);
        int pos;
        pos = 2047 - 8 * int'(b);
        return SBOX_BITS[pos -: 8];
    endfunction

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] tau_word(input logic [31:0] v);
        return {sbox_lookup(v[31:24]), sbox_lookup(v[23:16]),
                sbox_lookup(v[15:8]), sbox_lookup(v[7:0])};
    endfunction

    // Round function for data: tau then L
    function automatic logic [31:0] data_t(input logic [31:0] v);
        logic [31:0] b;
        b = tau_word(v);
        return b ^ rot_left(b, 2) ^ rot_left(b, 10) ^ rot_left(b, 18) ^ rot_left(b, 24);
    endfunction

    // Round function for the key schedule: tau then L'
    function automatic logic [31:0] key_t(input logic [31:0] v);
        logic [31:0] b;
        b = tau_word(v);
        return b ^ rot_left(b, 13) ^ rot_left(b, 23);
    endfunction

    // Expand the current 128-bit key into the 32 round keys
    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] ck;
        logic [31:0] t;
        k[0] = model_key_high[63:32] ^ 32'ha3b1bac6;
        k[1] = model_key_high[31:0]  ^ 32'h56aa3350;
        k[2] = model_key_low[63:32]  ^ 32'h677d9197;
        k[3] = model_key_low[31:0]   ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++)
        begin
            ck = '0;
            for (int j = 0; j < 4; j++)
                ck = {ck[23:0], 8'(((4 * i + j) * 7) & 255)};
            t = k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck;
            k[i % 4] = k[i % 4] ^ key_t(t);
            model_round_keys[i] = k[i % 4];
        end
    endfunction

    function automatic void apply_key_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [63:0] value);
        if (idx == REG_KEY_HIGH)
        begin
            model_key_high = value;
            expand_round_keys();
        end
        else if (idx == REG_KEY_LOW)
        begin
            model_key_low = value;
            expand_round_keys();
        end
    endfunction

    // Encrypt or decrypt one block with the current round keys; words leave reversed
    function automatic logic [127:0] sm4_crypt_block(input sm4_cmd_t cmd,
                                                     input logic [63:0] hi,
                                                     input logic [63:0] lo);
        logic [31:0] x [4];
        logic [31:0] rk;
        x[0] = hi[63:32];
        x[1] = hi[31:0];
        x[2] = lo[63:32];
        x[3] = lo[31:0];
        for (int i = 0; i < 32; i++)
        begin
            rk = (cmd == CMD_DEC) ? model_round_keys[31 - i] : model_round_keys[i];
            x[i % 4] = x[i % 4] ^ data_t(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ rk);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1_000_000;
        $display("sm4_block_cipher_top regression: fail");
        $finish;
    end

    // Record accepted input beats and predict their results
    always @(posedge clk)
    begin
        if (rst_n && din_bus.valid && din_bus.ready)
        begin
            void'(pending_blocks.pop_front());
            expected_blocks.push_back(sm4_crypt_block(din_bus.cmd, din_bus.block_high,
                                                      din_bus.block_low));
            beats_in++;
            in_taken = 1'b1;
        end
    end

    // Drive input beats from the pending queue, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!din_bus.valid || in_taken))
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                din_bus.valid <= 1'b0;
            end
            else if (jitter_on && pending_blocks.size() > 0 && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                din_bus.valid <= 1'b0;
            end
            else if (pending_blocks.size() > 0)
            begin
                din_bus.valid      <= 1'b1;
                din_bus.cmd        <= pending_blocks[0].cmd;
                din_bus.block_high <= pending_blocks[0].block_high;
                din_bus.block_low  <= pending_blocks[0].block_low;
            end
            else
            begin
                din_bus.valid <= 1'b0;
            end
        end
    end

    // Count down one long output hold-off once enough beats went in
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!squeeze_done && beats_in >= SQUEEZE_AT)
            begin
                squeeze_left = SQUEEZE_LEN;
                squeeze_done = 1'b1;
            end
            else if (squeeze_left > 0)
            begin
                squeeze_left--;
            end
        end
    end

    // Drive output ready: hold-off, random stall bursts, otherwise ready
    always @(negedge clk)
    begin
        if (squeeze_left > 0)
        begin
            dout_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            dout_bus.ready <= 1'b0;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            dout_bus.ready <= 1'b0;
        end
        else
        begin
            dout_bus.ready <= 1'b1;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat %016h_%016h",
                             dout_bus.result_high, dout_bus.result_low);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (dout_bus.result_high !== want[127:64] || dout_bus.result_low !== want[63:0])
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: expected %016h_%016h got %016h_%016h",
                                 want[127:64], want[63:0],
                                 dout_bus.result_high, dout_bus.result_low);
                end
            end
        end
    end

    task automatic queue_block(input sm4_cmd_t cmd, input logic [63:0] hi,
                               input logic [63:0] lo);
        cipher_req_t req;
        req.cmd        = cmd;
        req.block_high = hi;
        req.block_low  = lo;
        pending_blocks.push_back(req);
    endtask

    // Hold until every queued block is accepted and every result has come back
    task automatic wait_idle();
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_key_write(idx, value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // One phase of random traffic under a fresh key
    task automatic run_random_phase(input int n_items, input bit with_jitter);
        int          queued;
        int          pick;
        int          bitpos;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [127:0] ct;
        sm4_cmd_t    cmd;
        wait_idle();
        pick = $urandom_range(0, 2);
        if (pick != 1)
            write_key_reg(REG_KEY_HIGH, rand64());
        if (pick != 0)
            write_key_reg(REG_KEY_LOW, rand64());
        if ($urandom_range(0, 3) == 0)
            write_key_reg(CFG_IDX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                          rand64());
        jitter_on = with_jitter;
        queued = 0;
        while (queued < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                cmd = sm4_cmd_t'($urandom_range(0, 1));
                queue_block(cmd, rand64(), rand64());
                queued++;
            end
            else if (pick < 8)
            begin
                // Encrypt, then decrypt the predicted ciphertext back
                hi = rand64();
                lo = rand64();
                ct = sm4_crypt_block(CMD_ENC, hi, lo);
                queue_block(CMD_ENC, hi, lo);
                queue_block(CMD_DEC, ct[127:64], ct[63:0]);
                queued += 2;
            end
            else
            begin
                // Single set or cleared bit
                bitpos = $urandom_range(0, 127);
                {hi, lo} = 128'd1 << bitpos;
                if ($urandom_range(0, 1) == 1)
                    {hi, lo} = ~{hi, lo};
                cmd = sm4_cmd_t'($urandom_range(0, 1));
                queue_block(cmd, hi, lo);
                queued++;
            end
        end
    endtask

    // Reset, directed checks, random phases, verdict
    initial
    begin
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        din_bus.valid       = 1'b0;
        din_bus.cmd         = CMD_ENC;
        din_bus.block_high  = '0;
        din_bus.block_low   = '0;
        dout_bus.ready      = 1'b0;
        model_key_high      = '0;
        model_key_low       = '0;
        expand_round_keys();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Round keys from the all-zero key after reset
        queue_block(CMD_ENC, '0, '0);
        queue_block(CMD_DEC, '0, '0);
        queue_block(CMD_ENC, '1, '1);
        queue_block(CMD_DEC, '1, '1);
        wait_idle();

        // Published example, both directions
        write_key_reg(REG_KEY_HIGH, STD_WORD_HIGH);
        write_key_reg(REG_KEY_LOW, STD_WORD_LOW);
        queue_block(CMD_ENC, STD_WORD_HIGH, STD_WORD_LOW);
        queue_block(CMD_DEC, STD_CT_HIGH, STD_CT_LOW);
        queue_block(CMD_ENC, '0, '0);
        queue_block(CMD_DEC, '1, '1);
        wait_idle();

        // Writes to unused indexes leave the key alone
        write_key_reg(REG_FIRST_UNUSED, '1);
        write_key_reg(REG_LAST_UNUSED, '1);
        queue_block(CMD_ENC, STD_WORD_HIGH, STD_WORD_LOW);
        wait_idle();

        // All-ones key
        write_key_reg(REG_KEY_HIGH, '1);
        write_key_reg(REG_KEY_LOW, '1);
        queue_block(CMD_ENC, '0, '0);
        queue_block(CMD_ENC, '1, '1);
        queue_block(CMD_DEC, '1, '1);
        queue_block(CMD_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        wait_idle();

        // Clear one half of the key at a time
        write_key_reg(REG_KEY_HIGH, '0);
        queue_block(CMD_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        queue_block(CMD_DEC, STD_CT_HIGH, STD_CT_LOW);
        wait_idle();
        write_key_reg(REG_KEY_LOW, '0);
        queue_block(CMD_ENC, STD_WORD_HIGH, STD_WORD_LOW);
        queue_block(CMD_DEC, '0, '1);

        for (int p = 0; p < 5; p++)
            run_random_phase(PHASE_ITEMS, p < 4);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("sm4_block_cipher_top regression: pass");
        else
            $display("sm4_block_cipher_top regression: fail");
        $finish;
    end

endmodule
